FILE: design/fei_pkg.sv
// Shared definitions for the escape-time fractal iterator.
// Holds default parameter values, register indexes and the sequencer state type.
// No dependencies.
`default_nettype none

package fei_pkg;

  // Default widths of the fixed-point datapath and the ports.
  localparam int FRAC_BITS_DEF  = 28;
  localparam int WORD_BITS_DEF  = 32;
  localparam int PIXEL_BITS_DEF = 12;
  localparam int ITER_BITS_DEF  = 12;

  // Register reset values.
  localparam int SCALE_RESET = 2684354;
  localparam int LIMIT_RESET = 100;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 3;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t CFG_MODE     = 3'd0;
  localparam cfg_index_t CFG_SCALE    = 3'd1;
  localparam cfg_index_t CFG_OFFSET_RE = 3'd2;
  localparam cfg_index_t CFG_OFFSET_IM = 3'd3;
  localparam cfg_index_t CFG_JULIA_RE = 3'd4;
  localparam cfg_index_t CFG_JULIA_IM = 3'd5;
  localparam cfg_index_t CFG_LIMIT    = 3'd6;

  // Mode register values.
  localparam logic MODE_MANDELBROT = 1'b0;
  localparam logic MODE_JULIA      = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_X,
    ST_MAP_Y,
    ST_MAP_DONE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_CROSS,
    ST_UPDATE,
    ST_DONE
  } fei_state_t;

endpackage

`default_nettype wire

FILE: design/escape_time_fractal_iterator_unit.sv
// Top level of the escape-time fractal iterator (Mandelbrot and Julia).
// Depends on fei_pkg, fei_cfg (register file) and fei_mul (shared multiplier).
`default_nettype none

// Each accepted pixel (pixel_col, pixel_row) is mapped to the complex plane as
// pixel times pixel_scale plus offset, with saturation to the signed word. In
// Mandelbrot mode that point is c and z starts at zero; in Julia mode it is the
// start z and c comes from julia_re and julia_im. The unit then iterates
// z = z^2 + c while |z|^2 < 4 and the count is at most iteration_limit, and
// delivers the count in one output transfer. All work runs through a single
// word-by-word unsigned multiplier under a small sequencer: after the input
// transfer the pixel is mapped, every iteration steps through the real square,
// imaginary square, cross product and update, and the final escape test is
// followed by the output load. The input is stalled until the sequencer is
// back in idle. The finished count sits in an output register, so a new pixel
// is accepted while the previous result still waits for its transfer; the
// unit only holds its own result back while that register is full and the
// output is stalled.
// Configuration writes are accepted on every cycle and must only be issued
// while the unit is idle.

module escape_time_fractal_iterator_unit import fei_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int ITER_BITS  = ITER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Pixel input channel.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIXEL_BITS-1:0] pixel_col,
  input  wire logic [PIXEL_BITS-1:0] pixel_row,
  // Result channel.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [ITER_BITS:0]         iter_count,
  // Configuration write channel.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire cfg_index_t            cfg_index,
  input  wire logic [WORD_BITS-1:0]  cfg_data
);

  localparam int W          = WORD_BITS;
  localparam int ESC_SHIFT  = 2*FRAC_BITS + 2;

  // Saturate a sign and magnitude pair to the signed word range.
  function automatic logic [W-1:0] to_word(input logic neg, input logic [2*W:0] m);
    logic [2*W:0] lim;
    logic [W-1:0] v;
    lim = {{(W+2){1'b0}}, {(W-1){1'b1}}} + (2*W+1)'(neg);
    if (m > lim) v = lim[W-1:0];
    else         v = m[W-1:0];
    return neg ? (~v + 1'b1) : v;
  endfunction

  // Signed word addition that clamps instead of wrapping.
  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    return s[W-1:0];
  endfunction

  // Register file outputs.
  logic                 fractal_mode;
  logic [W-2:0]         pixel_scale;
  logic [W-1:0]         offset_re;
  logic [W-1:0]         offset_im;
  logic [W-1:0]         julia_re;
  logic [W-1:0]         julia_im;
  logic [ITER_BITS-1:0] iteration_limit;

  fei_cfg #(
    .WORD_BITS (WORD_BITS),
    .ITER_BITS (ITER_BITS)
  ) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fractal_mode    (fractal_mode),
    .pixel_scale     (pixel_scale),
    .offset_re       (offset_re),
    .offset_im       (offset_im),
    .julia_re        (julia_re),
    .julia_im        (julia_im),
    .iteration_limit (iteration_limit)
  );

  // Sequencer and datapath registers.
  fei_state_t           state;
  fei_state_t           state_next;
  logic [PIXEL_BITS-1:0] px_mag;
  logic                  px_neg;
  logic [PIXEL_BITS-1:0] py_mag;
  logic                  py_neg;
  logic [W-1:0]          map_x;
  logic [W-1:0]          zr;
  logic [W-1:0]          zi;
  logic [W-1:0]          cr;
  logic [W-1:0]          ci;
  logic [2*W-1:0]        sq_re;
  logic [2*W-1:0]        diff;
  logic                  diff_neg;
  logic [ITER_BITS:0]    count;

  // Shared multiplier.
  logic [W-1:0]   mul_a;
  logic [W-1:0]   mul_b;
  logic [2*W-1:0] mul_p;

  fei_mul #(
    .WORD_BITS (WORD_BITS)
  ) u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  logic                  in_xfer;
  logic                  out_free;
  logic [W-1:0]          zr_mag;
  logic [W-1:0]          zi_mag;
  logic [2*W:0]          mag2;
  logic                  stop;
  logic [W-1:0]          map_y;
  logic [W-1:0]          zr_new;
  logic [W-1:0]          zi_new;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Magnitudes of the current z; the most negative word maps to 2^(W-1).
  assign zr_mag = zr[W-1] ? (~zr + 1'b1) : zr;
  assign zi_mag = zi[W-1] ? (~zi + 1'b1) : zi;

  // In the cross-product cycle the multiplier holds the imaginary square.
  assign mag2 = {1'b0, sq_re} + {1'b0, mul_p};
  assign stop = ((mag2 >> ESC_SHIFT) != '0) || (count > {1'b0, iteration_limit});

  // Second mapped coordinate, from the product finished in the last cycle.
  assign map_y = sat_add(to_word(py_neg, {1'b0, mul_p}), offset_im);

  // Update of z from the stored difference of squares and the cross product.
  assign zr_new = sat_add(to_word(diff_neg, {1'b0, diff} >> FRAC_BITS), cr);
  assign zi_new = sat_add(to_word(zr[W-1] ^ zi[W-1], {mul_p, 1'b0} >> FRAC_BITS), ci);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and multiplier operand selection.
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = ST_MAP_X;
      end
      ST_MAP_X: begin
        mul_a      = W'(px_mag);
        mul_b      = {1'b0, pixel_scale};
        state_next = ST_MAP_Y;
      end
      ST_MAP_Y: begin
        mul_a      = W'(py_mag);
        mul_b      = {1'b0, pixel_scale};
        state_next = ST_MAP_DONE;
      end
      ST_MAP_DONE: begin
        state_next = ST_SQ_RE;
      end
      ST_SQ_RE: begin
        mul_a      = zr_mag;
        mul_b      = zr_mag;
        state_next = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        mul_a      = zi_mag;
        mul_b      = zi_mag;
        state_next = ST_CROSS;
      end
      ST_CROSS: begin
        mul_a      = zr_mag;
        mul_b      = zi_mag;
        state_next = stop ? ST_DONE : ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_SQ_RE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          px_neg <= pixel_col[PIXEL_BITS-1];
          py_neg <= pixel_row[PIXEL_BITS-1];
          px_mag <= pixel_col[PIXEL_BITS-1] ? (~pixel_col + 1'b1) : pixel_col;
          py_mag <= pixel_row[PIXEL_BITS-1] ? (~pixel_row + 1'b1) : pixel_row;
        end
      end
      ST_MAP_Y: begin
        map_x <= sat_add(to_word(px_neg, {1'b0, mul_p}), offset_re);
      end
      ST_MAP_DONE: begin
        count <= '0;
        if (fractal_mode == MODE_JULIA) begin
          zr <= map_x;
          zi <= map_y;
          cr <= julia_re;
          ci <= julia_im;
        end else begin
          zr <= '0;
          zi <= '0;
          cr <= map_x;
          ci <= map_y;
        end
      end
      ST_SQ_IM: begin
        sq_re <= mul_p;
      end
      ST_CROSS: begin
        // The sign of the real part follows which square is larger.
        diff_neg <= (sq_re < mul_p);
        diff     <= (sq_re < mul_p) ? (mul_p - sq_re) : (sq_re - mul_p);
      end
      ST_UPDATE: begin
        zr    <= zr_new;
        zi    <= zi_new;
        count <= count + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register: loaded from the finished count, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) iter_count <= count;
  end

endmodule

`default_nettype wire

FILE: design/fei_cfg.sv
// Configuration register file of the escape-time fractal iterator.
// Depends on fei_pkg for register indexes and reset values.
`default_nettype none

module fei_cfg import fei_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int ITER_BITS = ITER_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire cfg_index_t           cfg_index,
  input  wire logic [WORD_BITS-1:0] cfg_data,
  output logic                      fractal_mode,
  output logic [WORD_BITS-2:0]      pixel_scale,
  output logic [WORD_BITS-1:0]      offset_re,
  output logic [WORD_BITS-1:0]      offset_im,
  output logic [WORD_BITS-1:0]      julia_re,
  output logic [WORD_BITS-1:0]      julia_im,
  output logic [ITER_BITS-1:0]      iteration_limit
);

  // Writes are always taken; the sequencer only samples the registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fractal_mode    <= MODE_MANDELBROT;
      pixel_scale     <= (WORD_BITS-1)'(SCALE_RESET);
      offset_re       <= '0;
      offset_im       <= '0;
      julia_re        <= '0;
      julia_im        <= '0;
      iteration_limit <= ITER_BITS'(LIMIT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:      fractal_mode    <= cfg_data[0];
        CFG_SCALE:     pixel_scale     <= cfg_data[WORD_BITS-2:0];
        CFG_OFFSET_RE: offset_re       <= cfg_data;
        CFG_OFFSET_IM: offset_im       <= cfg_data;
        CFG_JULIA_RE:  julia_re        <= cfg_data;
        CFG_JULIA_IM:  julia_im        <= cfg_data;
        CFG_LIMIT:     iteration_limit <= cfg_data[ITER_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/fei_mul.sv
// Shared unsigned multiplier of the escape-time fractal iterator.
// One product per cycle, registered at the output. Depends on fei_pkg.
`default_nettype none

module fei_mul import fei_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic [WORD_BITS-1:0]   mul_a,
  input  wire logic [WORD_BITS-1:0]   mul_b,
  output logic      [2*WORD_BITS-1:0] mul_p
);

  always_ff @(posedge clk) begin
    mul_p <= (2*WORD_BITS)'(mul_a) * (2*WORD_BITS)'(mul_b);
  end

endmodule

`default_nettype wire

FILE: test/escape_time_fractal_iterator_unit_tb.sv
// Self-checking testbench for escape_time_fractal_iterator_unit (Mandelbrot and Julia).
// Depends on fei_pkg for widths, register indexes and mode values; drives all three channels.
`timescale 1ns / 100ps

module escape_time_fractal_iterator_unit_tb import fei_pkg::*;;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int WORD = WORD_BITS_DEF;
  localparam int PIX  = PIXEL_BITS_DEF;
  localparam int ITER = ITER_BITS_DEF;

  // Index past the end of the register list; writes to it must change nothing.
  localparam cfg_index_t CFG_UNUSED = 3'd7;

  // A table row asks for a prediction when its typed expectation is this value.
  localparam int PREDICTED = -1;

  // The longest runs come from two directed pixels and four random ones at the
  // top iteration limit; the other random pixels run at most 121 iterations.
  // With sender gaps and receiver stalls added, the limit leaves a wide margin.
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 64;

  localparam int RANDOM_PHASES    = 12;
  localparam int ZERO_LIMIT_PHASE = 2;
  localparam int DEEP_PHASE       = 7;
  localparam int PHASE_ITEMS      = 50;
  localparam int DEEP_ITEMS       = 4;

  typedef logic [ITER:0] count_t;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    cfg_index_t      index;
    logic [WORD-1:0] data;
    logic [PIX-1:0]  col;
    logic [PIX-1:0]  row;
    int              want;
  } plan_row_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [PIX-1:0]  pixel_col = '0;
  logic [PIX-1:0]  pixel_row = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  count_t          iter_count;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  cfg_index_t      cfg_index = CFG_MODE;
  logic [WORD-1:0] cfg_data = '0;

  escape_time_fractal_iterator_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .iter_count (iter_count),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the register file, updated on every accepted configuration
  // transfer. It starts at the documented reset values.
  logic                   cur_mode      = MODE_MANDELBROT;
  logic [WORD-2:0]        cur_scale     = (WORD-1)'(SCALE_RESET);
  logic signed [WORD-1:0] cur_off_re    = '0;
  logic signed [WORD-1:0] cur_off_im    = '0;
  logic signed [WORD-1:0] cur_julia_re  = '0;
  logic signed [WORD-1:0] cur_julia_im  = '0;
  logic [ITER-1:0]        cur_limit     = ITER'(LIMIT_RESET);

  // Escape counts still owed by the block, oldest first.
  count_t expected_counts[$];
  plan_row_t directed_plan[$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  // Blocking mirrors of the two valids, so that a valid is lowered at most once
  // per time step even when several helpers run back to back.
  bit  in_held = 1'b0;
  bit  cfg_held = 1'b0;
  bit  gaps_on = 1'b1;
  int  burst_left = 0;

  // A magnitude turned back into a word, saturated at the signed word limits.
  function automatic longint clamp_word(input bit neg, input logic [63:0] mag);
    logic [63:0] lim;
    lim = (64'd1 << (WORD - 1)) - 64'd1 + 64'(neg);
    if (mag > lim) mag = lim;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint add_sat(input longint a, input longint b);
    longint hi, lo, s;
    hi = (longint'(1) << (WORD - 1)) - 1;
    lo = -hi - 1;
    s = a + b;
    if (s > hi) s = hi;
    else if (s < lo) s = lo;
    return s;
  endfunction

  // Pixel times scale is exact, saturated to the word, then the offset is added
  // with saturation again.
  function automatic longint plane_coord(input logic signed [PIX-1:0] pix,
                                         input logic [WORD-2:0] scale,
                                         input longint off);
    longint p;
    logic [63:0] mag;
    p = longint'(pix);
    mag = 64'(p < 0 ? -p : p) * 64'(scale);
    return add_sat(clamp_word(p < 0, mag), off);
  endfunction

  // Walks z = z^2 + c at the block's widths. Squares and the magnitude are kept
  // exact at double width; the new components are truncated toward zero in
  // magnitude and then saturated after adding c.
  function automatic count_t predict_escape_count(input logic [PIX-1:0] col,
                                                  input logic [PIX-1:0] row);
    longint zr, zi, cr, ci, x, y, nr;
    logic [63:0] ar, ai, sr, si, twice_prod;
    logic [64:0] mag2;
    int unsigned n;
    x = plane_coord(col, cur_scale, longint'(cur_off_re));
    y = plane_coord(row, cur_scale, longint'(cur_off_im));
    if (cur_mode == MODE_JULIA) begin
      zr = x;
      zi = y;
      cr = longint'(cur_julia_re);
      ci = longint'(cur_julia_im);
    end else begin
      zr = 0;
      zi = 0;
      cr = x;
      ci = y;
    end
    n = 0;
    while (1'b1) begin
      ar = 64'(zr < 0 ? -zr : zr);
      ai = 64'(zi < 0 ? -zi : zi);
      sr = ar * ar;
      si = ai * ai;
      mag2 = {1'b0, sr} + {1'b0, si};
      if ((mag2 >> (2 * FRAC + 2)) != 0) break;
      if (n > cur_limit) break;
      if (sr >= si) nr = add_sat(clamp_word(1'b0, (sr - si) >> FRAC), cr);
      else nr = add_sat(clamp_word(1'b1, (si - sr) >> FRAC), cr);
      twice_prod = (ar * ai) << 1;
      zi = add_sat(clamp_word((zr < 0) != (zi < 0), twice_prod >> FRAC), ci);
      zr = nr;
      n++;
    end
    return count_t'(n);
  endfunction

  function automatic void plan_write(input cfg_index_t idx, input logic [WORD-1:0] data);
    plan_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.index = idx;
    r.data = data;
    directed_plan.push_back(r);
  endfunction

  function automatic void plan_pixel(input logic [PIX-1:0] col, input logic [PIX-1:0] row,
                                     input int want);
    plan_row_t r;
    r = '0;
    r.kind = ROW_PIXEL;
    r.col = col;
    r.row = row;
    r.want = want;
    directed_plan.push_back(r);
  endfunction

  // A signed word spread evenly over [-span, +span].
  function automatic logic [WORD-1:0] near_zero(input int unsigned span);
    return WORD'($urandom_range(0, 2 * span)) - WORD'(span);
  endfunction

  function automatic logic [PIX-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? {1'b1, {(PIX-1){1'b0}}} : {1'b0, {(PIX-1){1'b1}}};
      1, 2: return PIX'($urandom_range(0, 80)) - PIX'(40);
      default: return PIX'($urandom);
    endcase
  endfunction

  // Lowers the pixel valid and waits for every owed result, which leaves the
  // block idle and ready for register writes.
  task automatic drain_results();
    if (in_held) begin
      in_valid <= 1'b0;
      in_held = 1'b0;
    end
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  // One configuration transfer. The valid is left high so that a following
  // write goes out without a gap; the next pixel transfer lowers it.
  task automatic write_reg(input cfg_index_t idx, input logic [WORD-1:0] data);
    cfg_valid <= 1'b1;
    cfg_held = 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_MODE:      cur_mode = data[0];
      CFG_SCALE:     cur_scale = data[WORD-2:0];
      CFG_OFFSET_RE: cur_off_re = data;
      CFG_OFFSET_IM: cur_off_im = data;
      CFG_JULIA_RE:  cur_julia_re = data;
      CFG_JULIA_IM:  cur_julia_im = data;
      CFG_LIMIT:     cur_limit = data[ITER-1:0];
      default: ;
    endcase
  endtask

  // One pixel transfer. When gaps are on, the sender works in bursts; between
  // bursts it drops valid for a random number of cycles. The expectation is
  // recorded at the accepting edge, while the registers cannot change under it.
  task automatic send_pixel(input logic [PIX-1:0] col, input logic [PIX-1:0] row,
                            input int want);
    int gap;
    if (cfg_held) begin
      cfg_valid <= 1'b0;
      cfg_held = 1'b0;
    end
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (in_held) begin
        in_valid <= 1'b0;
        in_held = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_held = 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_counts.push_back(want >= 0 ? count_t'(want) : predict_escape_count(col, row));
  endtask

  // Result side: every transfer is checked against the oldest expectation, and
  // the stall line follows a randomly chosen style, from no stalls at all to
  // stalling with a chance of three in four.
  stall_style_t stall_style = STALL_NONE;
  int           style_left = 0;
  int           stall_phase = 0;
  count_t       want_count;

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_counts.size() == 0) begin
        $error("iter_count: no transfer expected, got %0d", iter_count);
        mismatch_count++;
      end else begin
        want_count = expected_counts.pop_front();
        if (iter_count !== want_count) begin
          $error("iter_count: expected %0d, got %0d", want_count, iter_count);
          mismatch_count++;
        end
      end
    end
    if (style_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      style_left = $urandom_range(32, 256);
    end
    style_left--;
    stall_phase = (stall_phase + 1) % 5;
    case (stall_style)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      default:        out_stall <= (stall_phase < 2);
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("escape_time_fractal_iterator_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    int phase, k, items;
    logic [WORD-1:0] noise;

    // Directed part. Rows with a typed count are cases that can be worked out by
    // hand; the rest go through the predictor.
    // Reset values: the origin never escapes, so it runs to limit plus one, and
    // the far corners saturate to about (-8,-8) and (8,8) and escape at once.
    plan_pixel(12'd0, 12'd0, LIMIT_RESET + 1);
    plan_pixel(12'h800, 12'h800, 1);
    plan_pixel(12'h7FF, 12'h7FF, 1);
    plan_pixel(12'd1, 12'hFFF, PREDICTED);
    // A zero limit gives one iteration unless the start point has escaped.
    plan_write(CFG_LIMIT, 32'd0);
    plan_pixel(12'd0, 12'd0, 1);
    plan_pixel(12'h7FF, 12'd0, 1);
    // Julia mode; the unused mode bits are all set and must be ignored.
    plan_write(CFG_MODE, {31'h7FFF_FFFF, MODE_JULIA});
    plan_pixel(12'h7FF, 12'd0, 0);
    plan_pixel(12'd0, 12'd0, 1);
    // Upper limit bits set as well, leaving the largest limit and count.
    plan_write(CFG_LIMIT, 32'hFFFF_FFFF);
    plan_pixel(12'd0, 12'd0, 4096);
    plan_write(CFG_MODE, {31'h7FFF_FFFF, MODE_MANDELBROT});
    plan_pixel(12'd0, 12'd0, 4096);
    // Zero scale maps every pixel onto the offset. At c = -2 the magnitude hits
    // exactly 4 after one step, which counts as escaped.
    plan_write(CFG_LIMIT, 32'd20);
    plan_write(CFG_SCALE, 32'd0);
    plan_write(CFG_OFFSET_RE, 32'hE000_0000);
    plan_pixel(12'h800, 12'h7FF, 1);
    // c = -1 bounces between -1 and 0 forever.
    plan_write(CFG_OFFSET_RE, 32'hF000_0000);
    plan_pixel(12'd5, 12'd5, 21);
    // Offset extremes.
    plan_write(CFG_OFFSET_RE, 32'h8000_0000);
    plan_write(CFG_OFFSET_IM, 32'h7FFF_FFFF);
    plan_pixel(12'd0, 12'd0, 1);
    // Largest scale; the top data bit lies above the register and is dropped.
    plan_write(CFG_SCALE, 32'hFFFF_FFFF);
    plan_write(CFG_OFFSET_RE, 32'd0);
    plan_write(CFG_OFFSET_IM, 32'd0);
    plan_pixel(12'd1, 12'hFFF, 1);
    plan_pixel(12'h800, 12'h7FF, 1);
    // Product and offset together overflow the word and saturate.
    plan_write(CFG_OFFSET_RE, 32'h7FFF_FFFF);
    plan_pixel(12'd1, 12'd0, 1);
    // Julia constants at both extremes.
    plan_write(CFG_SCALE, 32'h0004_0000);
    plan_write(CFG_OFFSET_RE, 32'd0);
    plan_write(CFG_MODE, {31'd0, MODE_JULIA});
    plan_write(CFG_JULIA_RE, 32'h8000_0000);
    plan_write(CFG_JULIA_IM, 32'h8000_0000);
    plan_pixel(12'd0, 12'd0, 1);
    plan_write(CFG_JULIA_RE, 32'h7FFF_FFFF);
    plan_write(CFG_JULIA_IM, 32'h7FFF_FFFF);
    plan_pixel(12'd0, 12'd0, 1);
    // A write past the register list, then a classic Julia constant near -0.8.
    plan_write(CFG_UNUSED, 32'hFFFF_FFFF);
    plan_write(CFG_JULIA_RE, 32'hF333_3333);
    plan_write(CFG_JULIA_IM, 32'h027E_F9DB);
    plan_pixel(12'd100, 12'hFCE, PREDICTED);
    plan_pixel(12'h800, 12'h7FF, 0);
    plan_write(CFG_MODE, {31'd0, MODE_MANDELBROT});
    plan_pixel(12'h7FF, 12'h7FF, PREDICTED);
    plan_pixel(12'hDA8, 12'd300, PREDICTED);
    plan_pixel(12'h800, 12'd0, PREDICTED);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(directed_plan[i].index, directed_plan[i].data);
      end else begin
        send_pixel(directed_plan[i].col, directed_plan[i].row, directed_plan[i].want);
      end
    end

    // Random part, in phases. Each phase waits for the block to go idle and
    // rewrites a random subset of the registers with noise in the unused bits.
    // Most scales put the pixel grid across the interesting region of the plane;
    // one phase uses the zero limit and one the largest, the latter with only a
    // handful of pixels close to the origin since most of them never escape.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      gaps_on = ($urandom_range(0, 3) != 0);
      noise = $urandom;
      if ($urandom_range(0, 3) != 0)
        write_reg(CFG_MODE, {noise[WORD-1:1], 1'($urandom_range(0, 1))});
      noise = $urandom;
      if (phase == DEEP_PHASE) begin
        write_reg(CFG_SCALE, {noise[WORD-1], 31'h0001_0000});
      end else if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: write_reg(CFG_SCALE, {noise[WORD-1], 31'd0});
          1: write_reg(CFG_SCALE, 32'hFFFF_FFFF);
          2: write_reg(CFG_SCALE, noise);
          default: write_reg(CFG_SCALE, {noise[WORD-1], 31'($urandom_range(1 << 15, 1 << 19))});
        endcase
      end
      noise = $urandom;
      if (phase == DEEP_PHASE) write_reg(CFG_OFFSET_RE, near_zero(1 << 24));
      else if ($urandom_range(0, 3) != 0)
        write_reg(CFG_OFFSET_RE, $urandom_range(0, 7) == 0 ? noise : near_zero(1 << 29));
      noise = $urandom;
      if (phase == DEEP_PHASE) write_reg(CFG_OFFSET_IM, near_zero(1 << 24));
      else if ($urandom_range(0, 3) != 0)
        write_reg(CFG_OFFSET_IM, $urandom_range(0, 7) == 0 ? noise : near_zero(1 << 29));
      noise = $urandom;
      if ($urandom_range(0, 3) != 0)
        write_reg(CFG_JULIA_RE, $urandom_range(0, 7) == 0 ? noise : near_zero(1 << 28));
      noise = $urandom;
      if ($urandom_range(0, 3) != 0)
        write_reg(CFG_JULIA_IM, $urandom_range(0, 7) == 0 ? noise : near_zero(1 << 28));
      noise = $urandom;
      if ($urandom_range(0, 5) == 0) write_reg(CFG_UNUSED, noise);
      noise = $urandom;
      if (phase == DEEP_PHASE) write_reg(CFG_LIMIT, {noise[WORD-1:ITER], {ITER{1'b1}}});
      else if (phase == ZERO_LIMIT_PHASE) write_reg(CFG_LIMIT, {noise[WORD-1:ITER], {ITER{1'b0}}});
      else write_reg(CFG_LIMIT, {noise[WORD-1:ITER], ITER'($urandom_range(1, 120))});

      items = (phase == DEEP_PHASE) ? DEEP_ITEMS : PHASE_ITEMS;
      for (k = 0; k < items; k++) send_pixel(random_pixel(), random_pixel(), PREDICTED);
    end

    // Wait for the last result, then give a stray transfer time to show up.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("escape_time_fractal_iterator_unit_tb: clean");
    end else begin
      $display("escape_time_fractal_iterator_unit_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/fei_pkg.sv
design/fei_cfg.sv
design/fei_mul.sv
design/escape_time_fractal_iterator_unit.sv
test/escape_time_fractal_iterator_unit_tb.sv
